// ===== rtl/core/dpma_pkg.sv =====
// ----------------------------------------------------------------------------
// dpma_pkg: shared types and constants for the dual photocell average
// beat formats of both channels and the default window and full scale
// ----------------------------------------------------------------------------
package dpma_pkg;

    // default filter shape
    localparam int WINDOW_DEF     = 100;
    localparam int FULL_SCALE_DEF = 1024;

    // fixed field widths
    localparam int SAMPLE_W  = 10;
    localparam int AVG_OUT_W = 11;
    localparam int PCT_W     = 7;

    // percent scale
    localparam int PERCENT_SCALE = 100;

    // input beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] rear_sample;
        logic [SAMPLE_W-1:0] forward_sample;
        logic                channel;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [AVG_OUT_W-1:0] average_counts;
        logic [PCT_W-1:0]     brightness_percent;
    } t_out_beat;

endpackage

// ===== rtl/core/dual_photocell_moving_average.sv =====
// ----------------------------------------------------------------------------
// dual_photocell_moving_average: two-channel boxcar filter with brightness
// running-sum moving average of a rear and a forward photocell stream
// ----------------------------------------------------------------------------
// Usage
//   input channel: i_in_valid / o_in_ready carry one beat with a rear sample,
//   a forward sample and a channel select (0 forward, 1 rear).
//   output channel: o_out_valid / i_out_ready carry one beat per input beat,
//   the floor average of the selected window after this beat's write and the
//   brightness percent derived from it.
//   throughput: one beat per cycle while i_out_ready stays high. One window memory holds both samples of a
//   slot; each beat reads the old pair and writes the new pair at the same
//   edge, so consecutive beats never collide on an entry.
//   pipeline: from input accept to o_out_valid a beat passes the memory read, sum
//   update, three stages of reciprocal divide for the average, two for the
//   percent, then the output register that holds the last correction.
//   reset: synchronous, active low. Windows read as full scale until the
//   write slot has wrapped once; sums start at WINDOW * FULL_SCALE. There is
//   no clearing pass, the block accepts beats right after reset.
//   stall: when the receiver holds i_out_ready low the pipeline fills up and
//   then o_in_ready drops; a bubble anywhere is squeezed out first.
// ----------------------------------------------------------------------------
module dual_photocell_moving_average #(
    parameter int WINDOW     = dpma_pkg::WINDOW_DEF,
    parameter int FULL_SCALE = dpma_pkg::FULL_SCALE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dpma_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dpma_pkg::t_out_beat o_out_data
);
    import dpma_pkg::*;

    // derived widths
    localparam int ENTRY_MAX = (FULL_SCALE > 1023) ? FULL_SCALE : 1023;
    localparam int AVG_W     = $clog2(ENTRY_MAX + 1);
    localparam int SUM_W     = $clog2(WINDOW * ENTRY_MAX + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DIFF_W    = $clog2(FULL_SCALE + 1);
    localparam int NUM_W     = $clog2(PERCENT_SCALE * FULL_SCALE + 1);
    localparam int STAGES    = 7;

    // reciprocal of the window, exact after one correction step
    localparam logic [63:0] M1     = (64'd1 << SUM_W) / WINDOW;
    localparam int          M1_W   = $clog2(M1 + 1);
    localparam int          PROD_W = SUM_W + M1_W;

    // reciprocal of full scale, premultiplied by the percent scale
    localparam logic [63:0] M2   = (64'd1 << NUM_W) / FULL_SCALE;
    localparam logic [63:0] K2   = M2 * PERCENT_SCALE;
    localparam int          K2_W = $clog2(K2 + 1);
    localparam int          P2_W = DIFF_W + K2_W;

    // sized constants
    localparam logic [SUM_W-1:0]  SUM_RST = SUM_W'(WINDOW * FULL_SCALE);
    localparam logic [SUM_W-1:0]  SUM_MAX = SUM_W'(WINDOW * ENTRY_MAX);
    localparam logic [SUM_W-1:0]  WIN_C   = SUM_W'(WINDOW);
    localparam logic [AVG_W-1:0]  FS_C    = AVG_W'(FULL_SCALE);
    localparam logic [NUM_W-1:0]  FSN_C   = NUM_W'(FULL_SCALE);
    localparam logic [NUM_W-1:0]  PCT_C   = NUM_W'(PERCENT_SCALE);
    localparam logic [M1_W-1:0]   M1_C    = M1_W'(M1);
    localparam logic [K2_W-1:0]   K2_C    = K2_W'(K2);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    // window memory and control state
    logic [2*SAMPLE_W-1:0] r_mem [WINDOW];
    logic [2*SAMPLE_W-1:0] r_rd;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_wrapped, n_wrapped;
    logic [SUM_W-1:0]      r_rear_sum, n_rear_sum;
    logic [SUM_W-1:0]      r_fwd_sum, n_fwd_sum;
    logic [STAGES:1]       r_valid;
    logic [STAGES+1:1]     rdy;
    logic                  r_out_valid;
    t_out_beat             r_out_data, n_out_data;
    logic                  in_acc;
    logic                  adv1;

    // stage payloads
    logic [SAMPLE_W-1:0] r1_rear, r1_fwd;
    logic                r1_chan, r1_wrapped;
    logic [SUM_W-1:0]    r2_sum, n2_sum;
    logic [PROD_W-1:0]   r3_prod;
    logic [SUM_W-1:0]    r3_sum;
    logic [AVG_W-1:0]    r4_qest, n4_qest;
    logic [SUM_W-1:0]    r4_t, n4_t, r4_sum;
    logic [AVG_W-1:0]    r5_avg, n5_avg;
    logic [DIFF_W-1:0]   r5_diff, n5_diff;
    logic [P2_W-1:0]     r6_p2;
    logic [NUM_W-1:0]    r6_num;
    logic [AVG_W-1:0]    r6_avg;
    logic [PCT_W-1:0]    r7_qe2, n7_qe2;
    logic [NUM_W-1:0]    r7_t2, n7_t2, r7_num;
    logic [AVG_W-1:0]    r7_avg;

    // combinational temporaries
    logic [AVG_W-1:0]  old_rear, old_fwd;
    logic [SUM_W:0]    rear_x, fwd_x;
    logic [SUM_W-1:0]  rem1;
    logic [NUM_W-1:0]  rem2;
    logic [PCT_W-1:0]  quo2;

    // ready chain, back to front
    always_comb begin
        rdy[STAGES+1] = !r_out_valid || i_out_ready;
        for (int k = STAGES; k >= 1; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    assign o_in_ready = rdy[1];
    assign in_acc     = i_in_valid && rdy[1];
    assign adv1       = r_valid[1] && rdy[2];

    // slot pointer and wrap flag
    always_comb begin
        n_slot    = r_slot;
        n_wrapped = r_wrapped;
        if (in_acc) begin
            if (r_slot == SLOT_LAST) begin
                n_slot    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_slot = r_slot + SLOT_W'(1);
            end
        end
    end

    // running sums: drop the oldest entry, add the new sample
    always_comb begin
        old_rear = r1_wrapped ? AVG_W'(r_rd[2*SAMPLE_W-1:SAMPLE_W]) : FS_C;
        old_fwd  = r1_wrapped ? AVG_W'(r_rd[SAMPLE_W-1:0]) : FS_C;
        rear_x   = (SUM_W+1)'(r_rear_sum) - (SUM_W+1)'(old_rear)
                   + (SUM_W+1)'(r1_rear);
        fwd_x    = (SUM_W+1)'(r_fwd_sum) - (SUM_W+1)'(old_fwd)
                   + (SUM_W+1)'(r1_fwd);
        n_rear_sum = adv1 ? SUM_W'(rear_x) : r_rear_sum;
        n_fwd_sum  = adv1 ? SUM_W'(fwd_x) : r_fwd_sum;
        n2_sum     = r1_chan ? SUM_W'(rear_x) : SUM_W'(fwd_x);
    end

    // average: quotient estimate, back-multiply, correction
    always_comb begin
        n4_qest = AVG_W'(r3_prod >> SUM_W);
        n4_t    = SUM_W'(n4_qest) * WIN_C;
        rem1    = r4_sum - r4_t;
        n5_avg  = r4_qest + AVG_W'(rem1 >= WIN_C);
        n5_diff = (n5_avg < FS_C) ? DIFF_W'(FS_C - n5_avg) : '0;
    end

    // percent: quotient estimate, back-multiply, correction
    always_comb begin
        n7_qe2 = PCT_W'(r6_p2 >> NUM_W);
        n7_t2  = NUM_W'(n7_qe2) * FSN_C;
        rem2   = r7_num - r7_t2;
        quo2   = r7_qe2 + PCT_W'(rem2 >= FSN_C);
        n_out_data.average_counts     = AVG_OUT_W'(r7_avg);
        n_out_data.brightness_percent = PCT_W'(PERCENT_SCALE) - quo2;
    end

    // window memory, read-before-write at the current slot
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd          <= r_mem[r_slot];
            r_mem[r_slot] <= {i_in_data.rear_sample, i_in_data.forward_sample};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_wrapped   <= 1'b0;
            r_rear_sum  <= SUM_RST;
            r_fwd_sum   <= SUM_RST;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot     <= n_slot;
            r_wrapped  <= n_wrapped;
            r_rear_sum <= n_rear_sum;
            r_fwd_sum  <= n_fwd_sum;
            if (rdy[1]) begin
                r_valid[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
            if (rdy[STAGES+1]) begin
                r_out_valid <= r_valid[STAGES];
            end
        end
    end

    // stage payloads move whenever the stage is free or draining
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_rear    <= i_in_data.rear_sample;
            r1_fwd     <= i_in_data.forward_sample;
            r1_chan    <= i_in_data.channel;
            r1_wrapped <= r_wrapped;
        end
        if (rdy[2]) begin
            r2_sum <= n2_sum;
        end
        if (rdy[3]) begin
            r3_prod <= PROD_W'(r2_sum) * PROD_W'(M1_C);
            r3_sum  <= r2_sum;
        end
        if (rdy[4]) begin
            r4_qest <= n4_qest;
            r4_t    <= n4_t;
            r4_sum  <= r3_sum;
        end
        if (rdy[5]) begin
            r5_avg  <= n5_avg;
            r5_diff <= n5_diff;
        end
        if (rdy[6]) begin
            r6_p2  <= P2_W'(r5_diff) * P2_W'(K2_C);
            r6_num <= NUM_W'(r5_diff) * PCT_C;
            r6_avg <= r5_avg;
        end
        if (rdy[7]) begin
            r7_qe2 <= n7_qe2;
            r7_t2  <= n7_t2;
            r7_num <= r6_num;
            r7_avg <= r6_avg;
        end
        if (rdy[STAGES+1]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // the write slot never leaves the window
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("write slot out of window");

    // running sums stay within the largest possible window total
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rear_sum <= SUM_MAX) && (r_fwd_sum <= SUM_MAX))
        else $error("running sum out of range");

    // a delivered percent is never above the scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.brightness_percent <= PCT_W'(PERCENT_SCALE)))
        else $error("brightness percent above scale");

    // a receiver that takes every beat never stalls the input side
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual photocell moving average
// drives rear/forward sample beats with random gaps and output stalls, keeps
// its own pair of boxcar windows and running sums, and checks every result
// beat field by field against the predicted average and brightness
// ----------------------------------------------------------------------------
module tb;
    import dpma_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int FULL        = FULL_SCALE_DEF;
    localparam int LATENCY     = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_BLOCKS = 16;
    localparam int BLOCK_LEN   = 100;

    // how hard a side idles during one stretch of beats
    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_FULL
    } t_idle_mode;

    // shape of the sample stream during one stretch of beats
    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_ALL_LOW,
        SHAPE_ALL_HIGH,
        SHAPE_RAMP,
        SHAPE_EDGES,
        SHAPE_NARROW
    } t_shape;

    // ------------------------------------------------------------------------
    // scoreboard: window model plus queue of predicted result beats
    // ------------------------------------------------------------------------
    class photocell_scoreboard;
        logic [AVG_OUT_W-1:0] rear_win [WIN];
        logic [AVG_OUT_W-1:0] fwd_win [WIN];
        int unsigned          slot;
        int unsigned          rear_total;
        int unsigned          fwd_total;
        t_out_beat            pending_results [$];
        int                   mismatch_count;
        int                   beats_in;
        int                   beats_out;

        function new();
            for (int k = 0; k < WIN; k++) begin
                rear_win[k] = AVG_OUT_W'(FULL);
                fwd_win[k]  = AVG_OUT_W'(FULL);
            end
            slot           = 0;
            rear_total     = WIN * FULL;
            fwd_total      = WIN * FULL;
            mismatch_count = 0;
            beats_in       = 0;
            beats_out      = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
            mismatch_count++;
        endtask

        // write both samples into the current slot, then average the selection
        function void note_beat(t_in_beat b);
            int unsigned avg;
            int unsigned diff;
            int unsigned pct;
            t_out_beat   res;
            rear_total    = rear_total - rear_win[slot] + b.rear_sample;
            fwd_total     = fwd_total - fwd_win[slot] + b.forward_sample;
            rear_win[slot] = AVG_OUT_W'(b.rear_sample);
            fwd_win[slot]  = AVG_OUT_W'(b.forward_sample);
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;
            avg  = b.channel ? rear_total / WIN : fwd_total / WIN;
            // average above full scale saturates the difference at zero
            diff = (avg < FULL) ? FULL - avg : 0;
            pct  = PERCENT_SCALE - (PERCENT_SCALE * diff) / FULL;
            res.average_counts     = avg[AVG_OUT_W-1:0];
            res.brightness_percent = pct[PCT_W-1:0];
            pending_results.push_back(res);
            beats_in++;
        endfunction

        task check_beat(t_out_beat got);
            t_out_beat want;
            beats_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.average_counts !== want.average_counts)
                    report_mismatch("average_counts", int'(got.average_counts),
                                    int'(want.average_counts));
                if (got.brightness_percent !== want.brightness_percent)
                    report_mismatch("brightness_percent", int'(got.brightness_percent),
                                    int'(want.brightness_percent));
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      r_in_valid;
    logic      o_in_ready;
    t_in_beat  r_in_data;
    logic      o_out_valid;
    logic      r_out_ready;
    t_out_beat o_out_data;

    photocell_scoreboard sb;
    t_idle_mode          send_mode;
    t_idle_mode          recv_mode;
    int                  cycle_count;

    dual_photocell_moving_average u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (r_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (r_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // cycle limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // monitor accepted beats on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (r_in_valid && o_in_ready)
                sb.note_beat(r_in_data);
            if (o_out_valid && r_out_ready)
                sb.check_beat(o_out_data);
        end
    end

    function automatic int draw_wait(t_idle_mode mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, 15);
        endcase
    endfunction

    // one beat on the input channel, after a gap drawn from the sender mode
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = draw_wait(send_mode);
        repeat (gap) begin
            @(negedge i_clk);
            r_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        r_in_valid <= 1'b1;
        r_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_fields(int rear, int fwd, int chan);
        t_in_beat b;
        b.rear_sample    = SAMPLE_W'(rear);
        b.forward_sample = SAMPLE_W'(fwd);
        b.channel        = chan[0];
        send_beat(b);
    endtask

    // hold the input side idle until every predicted result has come back
    task automatic drain_results();
        @(negedge i_clk);
        r_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int shaped_sample(t_shape shape, int idx, int base);
        case (shape)
            SHAPE_ALL_LOW:  return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 0;
            SHAPE_ALL_HIGH: return ($urandom_range(0, 9) == 0) ? $urandom_range(1020, 1023) : 1023;
            SHAPE_RAMP:     return (base + idx * 11) % 1024;
            SHAPE_EDGES:    return $urandom_range(0, 1) ? 1023 : 0;
            SHAPE_NARROW:   return (base + $urandom_range(0, 15)) % 1024;
            default:        return $urandom_range(0, 1023);
        endcase
    endfunction

    // receiver: one ready beat per result, after a stall drawn from its mode
    initial begin
        int stall;
        r_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(recv_mode);
            repeat (stall) begin
                @(negedge i_clk);
                r_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            r_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        t_shape shape;
        int     base_rear;
        int     base_fwd;
        int     chan_mode;
        int     chan;
        sb         = new();
        send_mode  = IDLE_NONE;
        recv_mode  = IDLE_NONE;
        r_in_valid = 1'b0;
        r_in_data  = '0;
        i_rst_n    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both channels, alternating and single bits
        send_fields(0, 0, 0);
        send_fields(0, 0, 1);
        send_fields(1023, 1023, 0);
        send_fields(1023, 1023, 1);
        send_fields(0, 1023, 0);
        send_fields(0, 1023, 1);
        send_fields(1023, 0, 0);
        send_fields(1023, 0, 1);
        send_fields('h155, 'h2AA, 0);
        send_fields('h2AA, 'h155, 1);
        send_fields(1, 512, 0);
        send_fields(512, 1, 1);
        send_fields(1022, 2, 1);
        send_fields(2, 1022, 0);
        send_fields(511, 511, 0);
        send_fields(511, 511, 1);
        drain_results();

        // four of the directed beats again and one new beat, with both sides idling hard
        send_mode = IDLE_FULL;
        recv_mode = IDLE_FULL;
        send_fields(1023, 0, 1);
        send_fields(0, 1023, 0);
        send_fields(1023, 1023, 1);
        send_fields(0, 0, 0);
        send_fields('h3FF, 'h200, 1);
        drain_results();

        // random stretches: each block has one sample shape and one idle pairing
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            shape     = t_shape'(blk % 6);
            send_mode = (blk == 0) ? IDLE_NONE : t_idle_mode'($urandom_range(0, 2));
            recv_mode = (blk == 0) ? IDLE_NONE : t_idle_mode'($urandom_range(0, 2));
            base_rear = $urandom_range(0, 1023);
            base_fwd  = $urandom_range(0, 1023);
            chan_mode = $urandom_range(0, 2);
            for (int i = 0; i < BLOCK_LEN; i++) begin
                // channel either random or held for the whole block
                chan = (chan_mode == 2) ? $urandom_range(0, 1) : chan_mode;
                send_fields(shaped_sample(shape, i, base_rear),
                            shaped_sample(shape, i + 37, base_fwd), chan);
            end
            if (blk % 4 == 3)
                drain_results();
        end

        // wait out the pipeline
        @(negedge i_clk);
        r_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY * 4) @(posedge i_clk);

        if (sb.pending() != 0)
            sb.report_mismatch("results left over", sb.pending(), 0);

        $display("Ran %0d input beats and checked %0d result beats", sb.beats_in,
                 sb.beats_out);
        $display("Streams: extremes, flat low/high, ramps, narrow bands, mixed idling");
        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dpma_pkg.sv
rtl/core/dual_photocell_moving_average.sv
tb/tb.sv
